### hw/rtl/iadpcm_pkg.sv
// Package for the IMA ADPCM block decoder: command types, limits and the
// step and index tables. No dependencies; all four modules import it.
package iadpcm_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_HEADER   = 2'd0;
    localparam logic [1:0] OP_PAIR     = 2'd1;
    localparam logic [1:0] OP_TRAILING = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam int IndexMax = 88;

    localparam logic signed [17:0] PRED_MAX = 18'sd32767;
    localparam logic signed [17:0] PRED_MIN = -18'sd32768;
    localparam logic [6:0]         IDX_MAX  = 7'd88;

    // Kind of a classified command in the queue.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PAIR   = 2'd1,
        KIND_SINGLE = 2'd2
    } t_kind;

    // One queued command, as handed from the front end to the back end.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] predictor;
        logic [6:0]         index_init;
        logic [7:0]         codes;
        logic               eob;
    } t_cmd;

    localparam logic [14:0] STEP_TABLE [0:IndexMax] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    // Step size for an index; indices past the table end read the last entry.
    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        if (idx > IDX_MAX) begin
            s = STEP_TABLE[IndexMax];
        end else begin
            s = STEP_TABLE[idx];
        end
        return s;
    endfunction

    // Index adjustment: small codes step down by one, large codes step up.
    function automatic logic signed [7:0] index_move(input logic [3:0] code);
        logic signed [7:0] m;
        if (code[2]) begin
            m = $signed({5'd0, code[1:0], 1'b0}) + 8'sd2;
        end else begin
            m = -8'sd1;
        end
        return m;
    endfunction

endpackage

### hw/rtl/iadpcm_in_if.sv
// Input channel of the ADPCM decoder: valid/ready handshake and one input word.
// Depends on nothing.
interface iadpcm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [15:0] header_predictor;
    logic signed [7:0]  header_step_raw;
    logic [7:0]         payload_byte;
    logic               end_of_block;

    modport source (
        output valid, opcode, header_predictor, header_step_raw, payload_byte,
               end_of_block,
        input  ready
    );
    modport sink (
        input  valid, opcode, header_predictor, header_step_raw, payload_byte,
               end_of_block,
        output ready
    );
endinterface

### hw/rtl/iadpcm_out_if.sv
// Output channel of the ADPCM decoder: valid/ready handshake and one sample word.
// Depends on nothing.
interface iadpcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;

    modport source (output valid, sample, last, input ready);
    modport sink   (input valid, sample, last, output ready);
endinterface

### hw/rtl/iadpcm_front.sv
// Front end of the ADPCM decoder: accepts input words, drops unused opcodes
// and classifies the rest into queue commands. Depends on iadpcm_pkg, iadpcm_in_if.
module iadpcm_front (
    iadpcm_in_if.sink        i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output iadpcm_pkg::t_cmd o_cmd
);
    import iadpcm_pkg::*;

    // Accept whenever the queue has room; unused opcodes are swallowed.
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full && (i_in.opcode != OP_UNUSED);

    // Classify the word and clamp the header step index into 0..88.
    always_comb begin
        o_cmd.predictor = i_in.header_predictor;
        o_cmd.codes     = i_in.payload_byte;
        o_cmd.eob       = i_in.end_of_block;
        if (i_in.header_step_raw < 8'sd0) begin
            o_cmd.index_init = 7'd0;
        end else if (i_in.header_step_raw > $signed({1'b0, IDX_MAX})) begin
            o_cmd.index_init = IDX_MAX;
        end else begin
            o_cmd.index_init = i_in.header_step_raw[6:0];
        end
        unique case (i_in.opcode)
            OP_HEADER: o_cmd.kind = KIND_HEADER;
            OP_PAIR:   o_cmd.kind = KIND_PAIR;
            default:   o_cmd.kind = KIND_SINGLE;
        endcase
    end
endmodule

### hw/rtl/iadpcm_queue.sv
// Short command queue between the decoder's front and back ends.
// Depends on iadpcm_pkg.
module iadpcm_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  iadpcm_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_not_empty,
    output iadpcm_pkg::t_cmd o_cmd
);
    import iadpcm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full      = (r_count == FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    // Pointer and fill-count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end
endmodule

### hw/rtl/iadpcm_back.sv
// Back end of the ADPCM decoder: executes queued commands, one nibble a cycle
// while its output register has room. Depends on iadpcm_pkg, iadpcm_out_if.
module iadpcm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_not_empty,
    input  iadpcm_pkg::t_cmd i_cmd,
    output logic             o_pop,
    iadpcm_out_if.source     o_out
);
    import iadpcm_pkg::*;

    logic signed [15:0] r_pred, n_pred;
    logic [6:0]         r_idx, n_idx;
    logic               r_second, n_second;
    logic               r_out_valid, n_out_valid;
    logic signed [15:0] r_sample;
    logic               r_last;

    logic               can_out;
    logic               produce;
    logic               out_last;
    logic [3:0]         code;
    logic [15:0]        step;
    logic [15:0]        delta;
    logic signed [17:0] sum;
    logic signed [15:0] sat;
    logic signed [7:0]  idx_sum;
    logic [6:0]         idx_new;

    assign can_out = !r_out_valid || o_out.ready;

    // The second nibble of a payload word is the high one.
    assign code = r_second ? i_cmd.codes[7:4] : i_cmd.codes[3:0];

    // Delta from the step size, then a saturating update of the predictor.
    always_comb begin
        step  = {1'b0, step_size(r_idx)};
        delta = step >> 3;
        if (code[2]) begin
            delta = delta + step;
        end
        if (code[1]) begin
            delta = delta + (step >> 1);
        end
        if (code[0]) begin
            delta = delta + (step >> 2);
        end
        if (code[3]) begin
            sum = 18'(r_pred) - $signed({2'b00, delta});
        end else begin
            sum = 18'(r_pred) + $signed({2'b00, delta});
        end
        if (sum > PRED_MAX) begin
            sat = 16'sh7FFF;
        end else if (sum < PRED_MIN) begin
            sat = -16'sh8000;
        end else begin
            sat = sum[15:0];
        end
        idx_sum = $signed({1'b0, r_idx}) + index_move(code);
        if (idx_sum < 8'sd0) begin
            idx_new = 7'd0;
        end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
            idx_new = IDX_MAX;
        end else begin
            idx_new = idx_sum[6:0];
        end
    end

    // Command sequencing: headers load state, nibbles need room at the output.
    always_comb begin
        n_pred   = r_pred;
        n_idx    = r_idx;
        n_second = r_second;
        o_pop    = 1'b0;
        produce  = 1'b0;
        out_last = 1'b0;
        if (i_q_not_empty) begin
            unique case (i_cmd.kind)
                KIND_HEADER: begin
                    n_pred = i_cmd.predictor;
                    n_idx  = i_cmd.index_init;
                    o_pop  = 1'b1;
                end
                KIND_PAIR: begin
                    if (can_out) begin
                        produce  = 1'b1;
                        n_pred   = sat;
                        n_idx    = idx_new;
                        out_last = r_second && i_cmd.eob;
                        o_pop    = r_second;
                        n_second = !r_second;
                    end
                end
                KIND_SINGLE: begin
                    if (can_out) begin
                        produce  = 1'b1;
                        n_pred   = sat;
                        n_idx    = idx_new;
                        out_last = i_cmd.eob;
                        o_pop    = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
        n_out_valid = produce || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= '0;
            r_idx       <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pred      <= n_pred;
            r_idx       <= n_idx;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_sample <= sat;
            r_last   <= out_last;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.sample = r_sample;
    assign o_out.last   = r_last;
endmodule

### hw/rtl/ima_adpcm_block_decoder_core.sv
// IMA ADPCM block decoder. A header word loads the predictor and step index
// and gives no sample; a payload word gives two samples, low nibble first; a
// trailing word gives one sample from its low nibble; opcode 3 is dropped.
// The back end's single decode unit updates predictor and index at most once a
// cycle, so a payload word's nibbles are decoded one after the other. A short
// command queue separates input acceptance from decoding, and the registered
// output is refilled in the same cycle its sample is taken, so samples can
// leave one per cycle; a nibble waits while an untaken sample sits there.
// Depends on iadpcm_pkg, iadpcm_in_if, iadpcm_out_if and the submodules.
module ima_adpcm_block_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iadpcm_in_if.sink     i_in,
    iadpcm_out_if.source  o_out
);
    import iadpcm_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // Front end: accept and classify.
    iadpcm_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // Command queue.
    iadpcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (front_cmd),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_not_empty (q_not_empty),
        .o_cmd       (head_cmd)
    );

    // Back end: decode and output.
    iadpcm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_out         (o_out)
    );
endmodule
